[hdl/qte_pkg.sv]
// qte_pkg: shared constants and the cordic angle table for quaternion_to_euler
// no dependencies
package qte_pkg;

   localparam int CORDIC_STAGES_DEF = 16;
   localparam int TAB_LEN           = 24;
   localparam int CW                = 38;  // cordic x/y width
   localparam int AW                = 27;  // angle accumulator width, degrees * 65536
   localparam int SQRT_STEPS        = 31;
   localparam int QW                = 34;  // numerator / denominator width
   localparam int SW                = 32;  // saturated asin argument width

   localparam logic signed [AW-1:0] DEG180     = AW'(180 * 65536);
   localparam logic signed [15:0]   ANGLE_LIM  = 16'sd23040;
   localparam logic signed [16:0]   PITCH_LIM  = 17'sd11520;
   localparam logic signed [QW-1:0] ONE_Q30    = QW'(64'sd1 <<< 30);

   typedef struct packed {
      logic signed [QW-1:0] roll_num;
      logic signed [QW-1:0] roll_den;
      logic signed [QW-1:0] yaw_num;
      logic signed [QW-1:0] yaw_den;
      logic signed [SW-1:0] sin_arg;
      logic                 clip;
   } side_type;

   // atan(2^-i) in degrees * 65536
   function automatic logic signed [AW-1:0] atan_tab(input int i);
      logic signed [AW-1:0] v;
      case (i)
         0:  v = AW'(2949120);
         1:  v = AW'(1740967);
         2:  v = AW'(919879);
         3:  v = AW'(466945);
         4:  v = AW'(234379);
         5:  v = AW'(117304);
         6:  v = AW'(58666);
         7:  v = AW'(29335);
         8:  v = AW'(14668);
         9:  v = AW'(7334);
         10: v = AW'(3667);
         11: v = AW'(1833);
         12: v = AW'(917);
         13: v = AW'(458);
         14: v = AW'(229);
         15: v = AW'(115);
         16: v = AW'(57);
         17: v = AW'(29);
         18: v = AW'(14);
         19: v = AW'(7);
         20: v = AW'(4);
         21: v = AW'(2);
         22: v = AW'(1);
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

[hdl/qte_isqrt.sv]
// qte_isqrt: pipelined bit-by-bit integer square root, one result bit per stage
// depends on qte_pkg
module qte_isqrt import qte_pkg::*; (
   input  logic        clock,
   input  logic        en,
   input  logic [60:0] rad,
   output logic [30:0] root
);

   logic [61:0] n_ff [1:SQRT_STEPS];
   logic [61:0] r_ff [1:SQRT_STEPS];

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
      localparam logic [61:0] BIT = 62'(1) << (60 - 2 * k);
      logic [61:0] n_cur, r_cur, t_in;
      if (k == 0) begin : g_first
         assign n_cur = {1'b0, rad};
         assign r_cur = '0;
      end else begin : g_next
         assign n_cur = n_ff[k];
         assign r_cur = r_ff[k];
      end
      assign t_in = r_cur + BIT;
      always_ff @(posedge clock) begin
         if (en) begin
            if (n_cur >= t_in) begin
               n_ff[k+1] <= n_cur - t_in;
               r_ff[k+1] <= (r_cur >> 1) + BIT;
            end else begin
               n_ff[k+1] <= n_cur;
               r_ff[k+1] <= r_cur >> 1;
            end
         end
      end
   end

   assign root = r_ff[SQRT_STEPS][30:0];

endmodule

[hdl/qte_cordic.sv]
// qte_cordic: pipelined vectoring cordic atan2, degrees * 128, clamped to +-180
// depends on qte_pkg
module qte_cordic import qte_pkg::*; #(
   parameter int STAGES = CORDIC_STAGES_DEF
) (
   input  logic                 clock,
   input  logic                 en,
   input  logic signed [CW-1:0] y_val,
   input  logic signed [CW-1:0] x_val,
   output logic signed [15:0]   angle_ff
);

   logic signed [CW-1:0] x_ff   [0:STAGES];
   logic signed [CW-1:0] y_ff   [0:STAGES];
   logic signed [AW-1:0] acc_ff [0:STAGES];
   logic                 zero_ff[0:STAGES];

   // quadrant fold
   always_ff @(posedge clock) begin
      if (en) begin
         zero_ff[0] <= (x_val == '0) && (y_val == '0);
         if (x_val[CW-1]) begin
            x_ff[0]   <= -x_val;
            y_ff[0]   <= -y_val;
            acc_ff[0] <= y_val[CW-1] ? -DEG180 : DEG180;
         end else begin
            x_ff[0]   <= x_val;
            y_ff[0]   <= y_val;
            acc_ff[0] <= '0;
         end
      end
   end

   for (genvar i = 0; i < STAGES; i++) begin : g_stage
      logic pos_in;
      assign pos_in = !y_ff[i][CW-1] && (y_ff[i] != '0);
      always_ff @(posedge clock) begin
         if (en) begin
            zero_ff[i+1] <= zero_ff[i];
            if (pos_in) begin
               x_ff[i+1]   <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1]   <= y_ff[i] - (x_ff[i] >>> i);
               acc_ff[i+1] <= acc_ff[i] + atan_tab(i);
            end else begin
               x_ff[i+1]   <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1]   <= y_ff[i] + (x_ff[i] >>> i);
               acc_ff[i+1] <= acc_ff[i] - atan_tab(i);
            end
         end
      end
   end

   logic signed [AW-1:0] rnd_in;
   logic signed [15:0]   angle_in;

   always_comb begin
      rnd_in = (acc_ff[STAGES] + AW'(256)) >>> 9;
      if (zero_ff[STAGES])
         angle_in = '0;
      else if (rnd_in > AW'(ANGLE_LIM))
         angle_in = ANGLE_LIM;
      else if (rnd_in < -AW'(ANGLE_LIM))
         angle_in = -ANGLE_LIM;
      else
         angle_in = rnd_in[15:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         angle_ff <= angle_in;
      end
   end

endmodule

[hdl/quaternion_to_euler.sv]
// quaternion_to_euler: top level, products, asin argument, sqrt and three cordics
// depends on qte_pkg, qte_isqrt, qte_cordic
//
// Converts a Q1.15 quaternion into roll, pitch and yaw in degrees * 128. One
// transaction is accepted per clock unless the pipeline is stalled; its result
// passes through three arithmetic stages, 31 square root stages, the cordic
// fold, CORDIC_STAGES rotation stages, the rounding stage and the output
// register, with stages above 24 treated as 24. Stalls freeze the pipeline only
// when its last stage holds a result the output register cannot take.
module quaternion_to_euler import qte_pkg::*; #(
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,  // quat_w, quat_x, quat_y, quat_z
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata   // roll_deg, pitch_deg, yaw_deg, pitch_clipped
);

   localparam int NS  = (CORDIC_STAGES > TAB_LEN) ? TAB_LEN : CORDIC_STAGES;
   localparam int LAT = 3 + SQRT_STEPS + NS + 2;

   logic           en;
   logic           out_load;
   logic [LAT-1:0] vld_ff;

   // stage 1: products
   logic signed [15:0] w, x, y, z;
   logic signed [31:0] ww_ff, xx_ff, zz_ff, yz_ff, wx_ff, xy_ff, wz_ff, xz_ff, wy_ff;

   assign w = req_tdata[15:0];
   assign x = req_tdata[31:16];
   assign y = req_tdata[47:32];
   assign z = req_tdata[63:48];

   always_ff @(posedge clock) begin
      if (en) begin
         ww_ff <= w * w;
         xx_ff <= x * x;
         zz_ff <= z * z;
         yz_ff <= y * z;
         wx_ff <= w * x;
         xy_ff <= x * y;
         wz_ff <= w * z;
         xz_ff <= x * z;
         wy_ff <= w * y;
      end
   end

   // stage 2: numerators, denominators, saturated asin argument
   side_type             s2_in, s2_ff;
   logic signed [QW-1:0] sm_in;

   always_comb begin
      s2_in.roll_num = (QW'(yz_ff) - QW'(wx_ff)) <<< 1;
      s2_in.roll_den = ((QW'(ww_ff) + QW'(zz_ff)) <<< 1) - ONE_Q30;
      s2_in.yaw_num  = (QW'(xy_ff) - QW'(wz_ff)) <<< 1;
      s2_in.yaw_den  = ((QW'(ww_ff) + QW'(xx_ff)) <<< 1) - ONE_Q30;
      sm_in          = (QW'(xz_ff) + QW'(wy_ff)) <<< 1;
      if (sm_in > ONE_Q30) begin
         s2_in.sin_arg = SW'(ONE_Q30);
         s2_in.clip    = 1'b1;
      end else if (sm_in < -ONE_Q30) begin
         s2_in.sin_arg = -SW'(ONE_Q30);
         s2_in.clip    = 1'b1;
      end else begin
         s2_in.sin_arg = sm_in[SW-1:0];
         s2_in.clip    = 1'b0;
      end
   end

   // stage 3: 1 - s*s in Q2.30 squared scale
   logic [60:0]          rad_ff;
   side_type             side_ff [0:SQRT_STEPS];
   logic signed [63:0]   rad_in;

   assign rad_in = (64'sd1 <<< 60) - (s2_ff.sin_arg * s2_ff.sin_arg);

   always_ff @(posedge clock) begin
      if (en) begin
         s2_ff      <= s2_in;
         rad_ff     <= rad_in[60:0];
         side_ff[0] <= s2_ff;
      end
   end

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_side
      always_ff @(posedge clock) begin
         if (en) begin
            side_ff[k+1] <= side_ff[k];
         end
      end
   end

   logic [30:0] root;

   qte_isqrt u_isqrt (
      .clock (clock),
      .en    (en),
      .rad   (rad_ff),
      .root  (root)
   );

   side_type             sd;
   logic signed [15:0]   roll_ang, pitch_ang, yaw_ang;
   logic                 clip_ff [0:NS+1];

   assign sd = side_ff[SQRT_STEPS];

   qte_cordic #(.STAGES(NS)) u_roll (
      .clock    (clock),
      .en       (en),
      .y_val    (CW'(sd.roll_num)),
      .x_val    (CW'(sd.roll_den)),
      .angle_ff (roll_ang)
   );

   qte_cordic #(.STAGES(NS)) u_pitch (
      .clock    (clock),
      .en       (en),
      .y_val    (CW'(sd.sin_arg)),
      .x_val    ({{(CW-31){1'b0}}, root}),
      .angle_ff (pitch_ang)
   );

   qte_cordic #(.STAGES(NS)) u_yaw (
      .clock    (clock),
      .en       (en),
      .y_val    (CW'(sd.yaw_num)),
      .x_val    (CW'(sd.yaw_den)),
      .angle_ff (yaw_ang)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         clip_ff[0] <= sd.clip;
      end
   end

   for (genvar j = 0; j < NS + 1; j++) begin : g_clip
      always_ff @(posedge clock) begin
         if (en) begin
            clip_ff[j+1] <= clip_ff[j];
         end
      end
   end

   // pitch sign flip and clamp
   logic signed [16:0] pneg_in;
   logic signed [14:0] pitch_in;

   always_comb begin
      pneg_in = -17'(pitch_ang);
      if (pneg_in > PITCH_LIM)
         pitch_in = PITCH_LIM[14:0];
      else if (pneg_in < -PITCH_LIM)
         pitch_in = 15'(-PITCH_LIM);
      else
         pitch_in = pneg_in[14:0];
   end

   // valid chain and output register
   logic        out_valid_ff;
   logic [47:0] out_data_ff;

   assign out_load   = !out_valid_ff || rsp_tready;
   assign en         = !vld_ff[LAT-1] || out_load;
   assign req_tready = en;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (en) begin
            vld_ff <= {vld_ff[LAT-2:0], req_tvalid};
         end
         if (out_load) begin
            out_valid_ff <= vld_ff[LAT-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_data_ff <= {clip_ff[NS+1], yaw_ang, pitch_in, roll_ang};
      end
   end

   // checks
   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[15:0]) <= ANGLE_LIM)
                  && ($signed(rsp_tdata[15:0]) >= -ANGLE_LIM)
                  && ($signed(rsp_tdata[46:31]) <= ANGLE_LIM)
                  && ($signed(rsp_tdata[46:31]) >= -ANGLE_LIM))
      else $error("angle outside +-180 degrees");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[LAT-1] && out_load) |=> rsp_tvalid)
      else $error("finished transaction lost at output register");

   a_freeze: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(vld_ff))
      else $error("pipeline moved while stalled");

endmodule
